// File: rtl/assert_macros.svh
// Assertion macros shared by the stack policy RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every sampled edge
`define RSCP_ASSERT_HOLDS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent holds in the same cycle as the antecedent
`define RSCP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent
`define RSCP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/rscp_pkg.sv
// Shared constants, codes and controller/datapath structs for the stack policy unit.
// No dependencies; every other RTL file but assert_macros.svh refers to it by scoped names.
`timescale 1ns / 1ps

package rscp_pkg;

    // Default parameter values
    localparam int DEPTH_DEFAULT        = 1024;
    localparam int DATA_WIDTH_DEFAULT   = 32;
    localparam int MIN_CAPACITY_DEFAULT = 10;

    // Fixed field widths
    localparam int PUSH_W     = 32;
    localparam int CNT_PORT_W = 11;
    localparam int TOTAL_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int GT_W       = 10;
    localparam int ST_W       = 8;
    localparam int GF_W       = 12;
    localparam int SF_W       = 8;
    localparam int INIT_W     = 11;
    localparam int QFRAC      = 8;

    // Register reset values
    localparam logic [GT_W-1:0]   GT_RESET       = 10'd256;
    localparam logic [ST_W-1:0]   ST_RESET       = 8'd38;
    localparam logic [GF_W-1:0]   GF_RESET       = 12'd512;
    localparam logic [SF_W-1:0]   SF_RESET       = 8'd128;
    localparam logic [INIT_W-1:0] INIT_CAP_RESET = 11'd10;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GROW_THRESHOLD   = 3'd0,
        REG_SHRINK_THRESHOLD = 3'd1,
        REG_GROW_FACTOR      = 3'd2,
        REG_SHRINK_FACTOR    = 3'd3,
        REG_INITIAL_CAPACITY = 3'd4
    } cfg_reg_t;

    // Transaction opcodes
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } opcode_t;

    // Operand select for the shared capacity multiplier
    typedef enum logic [1:0] {
        MUL_GT = 2'd0,
        MUL_ST = 2'd1,
        MUL_GF = 2'd2,
        MUL_SF = 2'd3
    } mul_sel_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic     start;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     decide;
        logic     load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic needs_check;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/rscp_in_if.sv
// Input channel of the stack policy unit: valid/ready handshake with push/pop payload.
// Depends on rscp_pkg for field widths.
`timescale 1ns / 1ps

interface rscp_in_if;
    logic                              valid;
    logic                              ready;
    logic                              opcode;
    logic signed [rscp_pkg::PUSH_W-1:0] push_value;

    modport source (output valid, output opcode, output push_value, input ready);
    modport sink   (input valid, input opcode, input push_value, output ready);
endinterface

// File: rtl/rscp_out_if.sv
// Result channel of the stack policy unit: valid/ready handshake with step result.
// Depends on rscp_pkg for field widths.
`timescale 1ns / 1ps

interface rscp_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [rscp_pkg::PUSH_W-1:0]     pop_data;
    logic                                  pop_valid;
    logic                                  push_dropped;
    logic        [rscp_pkg::CNT_PORT_W-1:0] occupancy;
    logic        [rscp_pkg::CNT_PORT_W-1:0] capacity;
    logic        [rscp_pkg::TOTAL_W-1:0]    resize_count;
    logic                                  resized;

    modport source (
        output valid, output pop_data, output pop_valid, output push_dropped,
        output occupancy, output capacity, output resize_count, output resized,
        input ready
    );
    modport sink (
        input valid, input pop_data, input pop_valid, input push_dropped,
        input occupancy, input capacity, input resize_count, input resized,
        output ready
    );
endinterface

// File: rtl/rscp_ctrl.sv
// Sequencing state machine of the stack policy unit.
// Depends on rscp_pkg for the command and status structs.
`timescale 1ns / 1ps

module rscp_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rscp_pkg::dp_status_t status,
    output rscp_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_MUL_GT = 7'b0000010,
        S_MUL_ST = 7'b0000100,
        S_MUL_GF = 7'b0001000,
        S_MUL_SF = 7'b0010000,
        S_DECIDE = 7'b0100000,
        S_RESULT = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    // Advance through the step: accept, four products and decide when a fill check runs, deliver
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.mul_sel  = rscp_pkg::MUL_GT;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = status.needs_check ? S_MUL_GT : S_RESULT;
                end
            end
            S_MUL_GT:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rscp_pkg::MUL_GT;
                state_next  = S_MUL_ST;
            end
            S_MUL_ST:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rscp_pkg::MUL_ST;
                state_next  = S_MUL_GF;
            end
            S_MUL_GF:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rscp_pkg::MUL_GF;
                state_next  = S_MUL_SF;
            end
            S_MUL_SF:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = rscp_pkg::MUL_SF;
                state_next  = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/rscp_dp.sv
// Datapath of the stack policy unit: entry store, counters, config registers,
// shared capacity multiplier, resize decision and result register. Depends on rscp_pkg.
`timescale 1ns / 1ps

module rscp_dp
#(
    parameter int DEPTH        = rscp_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH   = rscp_pkg::DATA_WIDTH_DEFAULT,
    parameter int MIN_CAPACITY = rscp_pkg::MIN_CAPACITY_DEFAULT
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  rscp_pkg::ctrl_cmd_t                    cmd,
    output rscp_pkg::dp_status_t                   status,
    input  logic                                   opcode,
    input  logic signed [rscp_pkg::PUSH_W-1:0]     push_value,
    input  logic                                   cfg_we,
    input  logic        [rscp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [rscp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                                   out_ready,
    output logic                                   out_valid,
    output logic signed [rscp_pkg::PUSH_W-1:0]     pop_data,
    output logic                                   pop_valid,
    output logic                                   push_dropped,
    output logic        [rscp_pkg::CNT_PORT_W-1:0] occupancy,
    output logic        [rscp_pkg::CNT_PORT_W-1:0] capacity,
    output logic        [rscp_pkg::TOTAL_W-1:0]    resize_count,
    output logic                                   resized
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int PW = CW + rscp_pkg::GF_W;
    localparam int XW = PW + rscp_pkg::QFRAC;
    localparam int EW = CW + rscp_pkg::INIT_W;
    localparam int DW = DATA_WIDTH;
    localparam logic [XW-1:0] MIN_SCALED = XW'(MIN_CAPACITY * (1 << rscp_pkg::QFRAC));

    // Saturate a capacity value to [1, DEPTH]
    function automatic logic [CW-1:0] clamp_cap(input logic [EW-1:0] v);
        if (v == '0)
            return CW'(1);
        else if (v > EW'(DEPTH))
            return CW'(DEPTH);
        else
            return v[CW-1:0];
    endfunction

    // Entry store
    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;
    logic          mem_we;
    logic          mem_re;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [DW-1:0] wdata;

    // Control state
    logic [CW-1:0]                  count_reg;
    logic [CW-1:0]                  cap_reg;
    logic [rscp_pkg::TOTAL_W-1:0]   total_reg;
    logic [rscp_pkg::GT_W-1:0]      gt_reg;
    logic [rscp_pkg::ST_W-1:0]      st_reg;
    logic [rscp_pkg::GF_W-1:0]      gf_reg;
    logic [rscp_pkg::SF_W-1:0]      sf_reg;
    logic                           out_valid_reg;

    // Per-item payload
    logic          op_reg;
    logic          acted_reg;
    logic          resized_reg;
    logic [PW-1:0] gt_prod_reg;
    logic [PW-1:0] st_prod_reg;
    logic [PW-1:0] gf_prod_reg;
    logic [PW-1:0] sf_prod_reg;

    // Result register
    logic signed [rscp_pkg::PUSH_W-1:0]     pop_data_reg;
    logic                                   pop_valid_reg;
    logic                                   push_dropped_reg;
    logic        [rscp_pkg::CNT_PORT_W-1:0] occupancy_reg;
    logic        [rscp_pkg::CNT_PORT_W-1:0] capacity_reg;
    logic        [rscp_pkg::TOTAL_W-1:0]    resize_count_reg;
    logic                                   resized_out_reg;

    logic                       is_push;
    logic                       needs_check;
    logic [CW-1:0]              count_m1;
    logic [DW+rscp_pkg::PUSH_W-1:0] wr_ext;
    logic [DW+rscp_pkg::PUSH_W-1:0] rd_ext;
    logic [rscp_pkg::PUSH_W-1:0]    pop_word;
    logic [EW-1:0]              count_ext;
    logic [EW-1:0]              cap_ext;
    logic [rscp_pkg::GF_W-1:0]  mul_b;
    logic [PW-1:0]              mul_p;
    logic [XW-1:0]              n_scaled;
    logic                       grow_hit;
    logic                       shrink_hit;
    logic                       resize_hit;
    logic [CW-1:0]              new_cap;

    // Step decode
    assign is_push     = (opcode == rscp_pkg::OP_PUSH);
    assign count_m1    = count_reg - CW'(1);
    assign needs_check = is_push ? (count_reg != CW'(DEPTH)) : (count_reg != '0);
    assign status.needs_check = needs_check;
    assign status.out_free    = !out_valid_reg || out_ready;

    // Store access: write on accepted push to a non-full store, read top on accepted non-empty pop
    assign mem_we = cmd.start && is_push && needs_check;
    assign mem_re = cmd.start && !is_push && needs_check;
    assign waddr  = count_reg[AW-1:0];
    assign raddr  = count_m1[AW-1:0];
    assign wr_ext = {{DW{1'b0}}, push_value};
    assign wdata  = wr_ext[DW-1:0];
    assign rd_ext = {{rscp_pkg::PUSH_W{1'b0}}, rdata_reg};
    assign pop_word = rd_ext[rscp_pkg::PUSH_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    // Shared multiplier: capacity times threshold or factor
    always_comb
    begin
        case (cmd.mul_sel)
            rscp_pkg::MUL_GT: mul_b = rscp_pkg::GF_W'(gt_reg);
            rscp_pkg::MUL_ST: mul_b = rscp_pkg::GF_W'(st_reg);
            rscp_pkg::MUL_GF: mul_b = gf_reg;
            rscp_pkg::MUL_SF: mul_b = rscp_pkg::GF_W'(sf_reg);
            default:          mul_b = gf_reg;
        endcase
    end

    assign mul_p = PW'(cap_reg) * PW'(mul_b);

    // Resize decision on registered products
    assign n_scaled   = XW'({count_reg, {rscp_pkg::QFRAC{1'b0}}});
    assign grow_hit   = (n_scaled >= XW'(gt_prod_reg));
    assign shrink_hit = !grow_hit && (n_scaled <= XW'(st_prod_reg))
                        && (XW'(sf_prod_reg) >= MIN_SCALED);
    assign resize_hit = grow_hit || shrink_hit;
    assign new_cap    = clamp_cap(grow_hit ? EW'(gf_prod_reg[PW-1:rscp_pkg::QFRAC])
                                           : EW'(sf_prod_reg[PW-1:rscp_pkg::QFRAC]));

    // Control state: counts, capacity, config, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= clamp_cap(EW'(rscp_pkg::INIT_CAP_RESET));
            total_reg     <= '0;
            gt_reg        <= rscp_pkg::GT_RESET;
            st_reg        <= rscp_pkg::ST_RESET;
            gf_reg        <= rscp_pkg::GF_RESET;
            sf_reg        <= rscp_pkg::SF_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start && needs_check)
            begin
                count_reg <= is_push ? (count_reg + CW'(1)) : count_m1;
            end

            if (cmd.decide && resize_hit)
            begin
                total_reg <= total_reg + rscp_pkg::TOTAL_W'(1);
                cap_reg   <= new_cap;
            end
            else if (cfg_we &&
                     (rscp_pkg::cfg_reg_t'(cfg_index) == rscp_pkg::REG_INITIAL_CAPACITY))
            begin
                cap_reg <= clamp_cap(EW'(cfg_wdata[rscp_pkg::INIT_W-1:0]));
            end

            if (cfg_we)
            begin
                case (rscp_pkg::cfg_reg_t'(cfg_index))
                    rscp_pkg::REG_GROW_THRESHOLD:   gt_reg <= cfg_wdata[rscp_pkg::GT_W-1:0];
                    rscp_pkg::REG_SHRINK_THRESHOLD: st_reg <= cfg_wdata[rscp_pkg::ST_W-1:0];
                    rscp_pkg::REG_GROW_FACTOR:      gf_reg <= cfg_wdata[rscp_pkg::GF_W-1:0];
                    rscp_pkg::REG_SHRINK_FACTOR:    sf_reg <= cfg_wdata[rscp_pkg::SF_W-1:0];
                    default:                        ;
                endcase
            end

            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Per-item payload: opcode, outcome, products, change flag
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg      <= opcode;
            acted_reg   <= needs_check;
            resized_reg <= 1'b0;
        end
        if (cmd.mul_en)
        begin
            case (cmd.mul_sel)
                rscp_pkg::MUL_GT: gt_prod_reg <= mul_p;
                rscp_pkg::MUL_ST: st_prod_reg <= mul_p;
                rscp_pkg::MUL_GF: gf_prod_reg <= mul_p;
                rscp_pkg::MUL_SF: sf_prod_reg <= mul_p;
                default:          gf_prod_reg <= mul_p;
            endcase
        end
        if (cmd.decide)
        begin
            resized_reg <= resize_hit && (new_cap != cap_reg);
        end
    end

    assign count_ext = {{rscp_pkg::INIT_W{1'b0}}, count_reg};
    assign cap_ext   = {{rscp_pkg::INIT_W{1'b0}}, cap_reg};

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            pop_data_reg     <= (op_reg == rscp_pkg::OP_POP && acted_reg) ? pop_word : '0;
            pop_valid_reg    <= (op_reg == rscp_pkg::OP_POP) && acted_reg;
            push_dropped_reg <= (op_reg == rscp_pkg::OP_PUSH) && !acted_reg;
            occupancy_reg    <= count_ext[rscp_pkg::CNT_PORT_W-1:0];
            capacity_reg     <= cap_ext[rscp_pkg::CNT_PORT_W-1:0];
            resize_count_reg <= total_reg;
            resized_out_reg  <= resized_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pop_data     = pop_data_reg;
    assign pop_valid    = pop_valid_reg;
    assign push_dropped = push_dropped_reg;
    assign occupancy    = occupancy_reg;
    assign capacity     = capacity_reg;
    assign resize_count = resize_count_reg;
    assign resized      = resized_out_reg;

endmodule

// File: rtl/resizing_stack_capacity_policy_unit.sv
// Step: when no fill check runs (dropped push, empty pop) the result is loaded straight
// after accept; otherwise the shared capacity multiplier takes four products in turn, then
// a decide state runs. One item at a time, and the result waits for a free output slot.
// The entry store has one write and one registered read port, used once per item.
// Reset (rst_n low, async): empty stack, capacity 10, count zero, registers at their
// reset values; the entry store is not cleared.
// Top level of the stack policy unit; depends on rscp_pkg, rscp_in_if, rscp_out_if,
// rscp_ctrl, rscp_dp and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module resizing_stack_capacity_policy_unit
#(
    parameter int DEPTH        = rscp_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH   = rscp_pkg::DATA_WIDTH_DEFAULT,
    parameter int MIN_CAPACITY = rscp_pkg::MIN_CAPACITY_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    rscp_in_if.sink                             in_ch,
    rscp_out_if.source                          out_ch,
    input  logic                                cfg_we,
    input  logic [rscp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rscp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    rscp_pkg::ctrl_cmd_t  cmd;
    rscp_pkg::dp_status_t status;
    logic                 in_ready;

    // Sequencer
    rscp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    assign in_ch.ready = in_ready;

    // Store, policy arithmetic and result register
    rscp_dp
    #(
        .DEPTH        (DEPTH),
        .DATA_WIDTH   (DATA_WIDTH),
        .MIN_CAPACITY (MIN_CAPACITY)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .opcode       (in_ch.opcode),
        .push_value   (in_ch.push_value),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .out_ready    (out_ch.ready),
        .out_valid    (out_ch.valid),
        .pop_data     (out_ch.pop_data),
        .pop_valid    (out_ch.pop_valid),
        .push_dropped (out_ch.push_dropped),
        .occupancy    (out_ch.occupancy),
        .capacity     (out_ch.capacity),
        .resize_count (out_ch.resize_count),
        .resized      (out_ch.resized)
    );

    // One item in flight: no second transaction right after an accept
    `RSCP_ASSERT_NEXT(a_single_item, in_ch.valid && in_ch.ready, !in_ch.ready, "second item accepted while busy")

    // Result is only loaded into a free output slot
    `RSCP_ASSERT_IMPLIES(a_load_free, cmd.load_out, status.out_free, "result overwrote a pending transaction")

    // A step either pops, drops a push, or neither
    `RSCP_ASSERT_IMPLIES(a_outcome_excl, out_ch.valid, !(out_ch.pop_valid && out_ch.push_dropped), "pop and dropped push in one result")

    // Start and result load never coincide
    `RSCP_ASSERT_HOLDS(a_cmd_excl, !(cmd.start && cmd.load_out), "start and result load together")

endmodule

// File: dv/testbench.sv
// Self-checking testbench for resizing_stack_capacity_policy_unit: drives push/pop
// transactions and policy register writes, and checks every result against a predictor.
// Depends on rscp_pkg, rscp_in_if, rscp_out_if and the unit's RTL.
`timescale 1ns / 1ps

module testbench;
    import rscp_pkg::*;

    localparam int STORE_DEPTH   = DEPTH_DEFAULT;
    localparam int MIN_CAP       = MIN_CAPACITY_DEFAULT;
    localparam int SETTLE_CYCLES = 12;
    localparam int LIMIT_CYCLES  = 400000;

    // Indexes past the last register; writes there must leave the policy alone
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic [PUSH_W-1:0]     pop_data;
        logic                  pop_valid;
        logic                  push_dropped;
        logic [CNT_PORT_W-1:0] occupancy;
        logic [CNT_PORT_W-1:0] capacity;
        logic [TOTAL_W-1:0]    resize_count;
        logic                  resized;
    } step_result_t;

    // Predictor of the stack and its capacity policy, plus the queue of expected steps
    class stack_policy_scoreboard;
        logic [PUSH_W-1:0]     entries [STORE_DEPTH];
        logic [CNT_PORT_W-1:0] held;
        logic [CNT_PORT_W-1:0] cap;
        logic [TOTAL_W-1:0]    total;
        logic [GT_W-1:0]       grow_thr;
        logic [ST_W-1:0]       shrink_thr;
        logic [GF_W-1:0]       grow_fac;
        logic [SF_W-1:0]       shrink_fac;
        logic [INIT_W-1:0]     init_cap;
        step_result_t          expected_steps [$];
        int unsigned           errors;

        function new();
            grow_thr   = GT_RESET;
            shrink_thr = ST_RESET;
            grow_fac   = GF_RESET;
            shrink_fac = SF_RESET;
            init_cap   = INIT_CAP_RESET;
            held       = '0;
            cap        = saturate(INIT_CAP_RESET);
            total      = '0;
            errors     = 0;
        endfunction

        function logic [CNT_PORT_W-1:0] saturate(longint unsigned v);
            if (v < 1)
                return CNT_PORT_W'(1);
            if (v > STORE_DEPTH)
                return CNT_PORT_W'(STORE_DEPTH);
            return v[CNT_PORT_W-1:0];
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_GROW_THRESHOLD:   grow_thr   = val[GT_W-1:0];
                REG_SHRINK_THRESHOLD: shrink_thr = val[ST_W-1:0];
                REG_GROW_FACTOR:      grow_fac   = val[GF_W-1:0];
                REG_SHRINK_FACTOR:    shrink_fac = val[SF_W-1:0];
                REG_INITIAL_CAPACITY:
                begin
                    init_cap = val[INIT_W-1:0];
                    cap      = saturate(val[INIT_W-1:0]);
                end
                default: ;
            endcase
        endfunction

        // Compare fill against the thresholds and rescale; return 1 when capacity moved
        function bit apply_capacity_policy();
            longint unsigned fill_q;
            longint unsigned c;
            logic [CNT_PORT_W-1:0] next_cap;
            fill_q = held;
            fill_q = fill_q * 256;
            c      = cap;
            if (fill_q >= grow_thr * c)
                next_cap = saturate((c * grow_fac) / 256);
            else if (fill_q <= shrink_thr * c && c * shrink_fac >= MIN_CAP * 256)
                next_cap = saturate((c * shrink_fac) / 256);
            else
                return 0;
            total = total + 1'b1;
            if (next_cap != cap)
            begin
                cap = next_cap;
                return 1;
            end
            return 0;
        endfunction

        function void note_input(opcode_t op, logic [PUSH_W-1:0] value);
            step_result_t exp_r;
            exp_r = '0;
            if (op == OP_PUSH)
            begin
                if (held == STORE_DEPTH)
                    exp_r.push_dropped = 1'b1;
                else
                begin
                    entries[held] = value;
                    held = held + 1'b1;
                    exp_r.resized = apply_capacity_policy();
                end
            end
            else if (held != 0)
            begin
                held = held - 1'b1;
                exp_r.pop_data  = entries[held];
                exp_r.pop_valid = 1'b1;
                exp_r.resized   = apply_capacity_policy();
            end
            exp_r.occupancy    = held;
            exp_r.capacity     = cap;
            exp_r.resize_count = total;
            expected_steps.push_back(exp_r);
        endfunction

        function void check_result(step_result_t got);
            step_result_t exp_r;
            if (expected_steps.size() == 0)
            begin
                $error("result transaction with no expected step pending");
                errors++;
                return;
            end
            exp_r = expected_steps.pop_front();
            if (got.pop_data !== exp_r.pop_data)
            begin
                $error("pop_data expected %0d actual %0d",
                       $signed(exp_r.pop_data), $signed(got.pop_data));
                errors++;
            end
            if (got.pop_valid !== exp_r.pop_valid)
            begin
                $error("pop_valid expected %0d actual %0d", exp_r.pop_valid, got.pop_valid);
                errors++;
            end
            if (got.push_dropped !== exp_r.push_dropped)
            begin
                $error("push_dropped expected %0d actual %0d",
                       exp_r.push_dropped, got.push_dropped);
                errors++;
            end
            if (got.occupancy !== exp_r.occupancy)
            begin
                $error("occupancy expected %0d actual %0d", exp_r.occupancy, got.occupancy);
                errors++;
            end
            if (got.capacity !== exp_r.capacity)
            begin
                $error("capacity expected %0d actual %0d", exp_r.capacity, got.capacity);
                errors++;
            end
            if (got.resize_count !== exp_r.resize_count)
            begin
                $error("resize_count expected %0d actual %0d",
                       exp_r.resize_count, got.resize_count);
                errors++;
            end
            if (got.resized !== exp_r.resized)
            begin
                $error("resized expected %0d actual %0d", exp_r.resized, got.resized);
                errors++;
            end
        endfunction

        function int pending();
            return expected_steps.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    rscp_in_if  in_ch ();
    rscp_out_if out_ch ();

    stack_policy_scoreboard sb = new();

    int send_idle_pct;
    int recv_stall_pct;
    int recv_hold;
    int cycle_count;

    resizing_stack_capacity_policy_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stop a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("testbench: errors");
        $finish;
    end

    // Accept results, check them, and stall at random or for a requested stretch
    initial
    begin
        step_result_t got;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                got.pop_data     = out_ch.pop_data;
                got.pop_valid    = out_ch.pop_valid;
                got.push_dropped = out_ch.push_dropped;
                got.occupancy    = out_ch.occupancy;
                got.capacity     = out_ch.capacity;
                got.resize_count = out_ch.resize_count;
                got.resized      = out_ch.resized;
                sb.check_result(got);
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one transaction, idling first at random; note it once accepted
    task automatic send_item(input opcode_t op, input logic [PUSH_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.opcode     <= op;
        in_ch.push_value <= value;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        sb.note_input(op, value);
    endtask

    // Hold input idle until every expected step has come back, then let the unit settle
    task automatic drain_outstanding();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.write_reg(idx, val);
    endtask

    task automatic program_policy(input int gt, input int st, input int gf, input int sf,
                                  input int init_cap);
        write_reg(REG_GROW_THRESHOLD, CFG_DATA_W'(gt));
        write_reg(REG_SHRINK_THRESHOLD, CFG_DATA_W'(st));
        write_reg(REG_GROW_FACTOR, CFG_DATA_W'(gf));
        write_reg(REG_SHRINK_FACTOR, CFG_DATA_W'(sf));
        write_reg(REG_INITIAL_CAPACITY, CFG_DATA_W'(init_cap));
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Pick a field value, favoring its extremes now and then
    function automatic int pick_field(input int lo, input int hi);
        case ($urandom_range(5))
            0: return lo;
            1: return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    task automatic program_random_policy();
        program_policy(pick_field(0, 1023), pick_field(0, 255), pick_field(0, 4095),
                       pick_field(0, 255), pick_field(1, STORE_DEPTH));
    endtask

    function automatic logic [PUSH_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic set_traffic(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
        endcase
    endtask

    // Bursts of mostly pushes or mostly pops, with the odd opposite op as noise
    task automatic run_bursts(input int count, input int push_pct);
        int      done;
        int      burst_len;
        bit      push_heavy;
        opcode_t op;
        done = 0;
        while (done < count)
        begin
            burst_len  = $urandom_range(24, 1);
            push_heavy = ($urandom_range(99) < push_pct);
            for (int i = 0; i < burst_len && done < count; i++)
            begin
                if ($urandom_range(99) < 12)
                    op = push_heavy ? OP_POP : OP_PUSH;
                else
                    op = push_heavy ? OP_PUSH : OP_POP;
                send_item(op, pick_value());
                done++;
            end
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        in_ch.valid      = 1'b0;
        in_ch.opcode     = OP_PUSH;
        in_ch.push_value = '0;
        recv_hold        = 0;
        set_traffic(0);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        drain_outstanding();

        // Directed: empty pop, value extremes, grow at full fill, shrink on unwind
        send_item(OP_POP, '0);
        send_item(OP_PUSH, 32'h7FFF_FFFF);
        send_item(OP_PUSH, 32'h8000_0000);
        send_item(OP_PUSH, 32'h0000_0000);
        send_item(OP_PUSH, 32'hFFFF_FFFF);
        send_item(OP_PUSH, 32'h0000_0001);
        send_item(OP_PUSH, 32'h5555_5555);
        send_item(OP_PUSH, 32'hAAAA_AAAA);
        send_item(OP_PUSH, 32'h1234_5678);
        send_item(OP_PUSH, 32'h8000_0001);
        send_item(OP_PUSH, 32'h7FFF_FFFE);
        repeat (11) send_item(OP_POP, '0);
        drain_outstanding();

        // Random policy; long receiver hold so the unit backs up and stalls input
        program_random_policy();
        recv_hold = 300;
        run_bursts(150, 60);
        drain_outstanding();

        // Fill the physical store, push into it while full, then unwind
        set_traffic(1);
        program_policy(GT_RESET, ST_RESET, GF_RESET, SF_RESET, 1);
        while (sb.held < STORE_DEPTH)
            send_item(OP_PUSH, pick_value());
        repeat (5) send_item(OP_PUSH, pick_value());
        run_bursts(200, 20);
        drain_outstanding();

        // Grow on every step at full capacity: saturation leaves capacity unchanged
        set_traffic(2);
        program_policy(0, 255, 4095, 255, STORE_DEPTH);
        run_bursts(100, 50);
        drain_outstanding();

        // Zero factors and thresholds collapse capacity to one
        set_traffic(3);
        program_policy(0, 0, 0, 0, STORE_DEPTH);
        run_bursts(60, 50);
        drain_outstanding();

        // Writes past the last register are ignored
        write_reg(REG_UNUSED_LO, '1);
        write_reg(REG_UNUSED_HI, CFG_DATA_W'($urandom));
        @(posedge clk);
        cfg_we <= 1'b0;
        set_traffic(0);
        program_policy(1023, 255, pick_field(0, 4095), 255, pick_field(1, STORE_DEPTH));
        run_bursts(100, 30);
        drain_outstanding();

        // Random policies across every traffic mode
        for (int p = 0; p < 4; p++)
        begin
            set_traffic(p);
            program_random_policy();
            run_bursts(60, 50);
            drain_outstanding();
        end

        // Wind down
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
